// ===== src/oaws_pkg.sv =====
// ----------------------------------------------------------------------------
// oaws_pkg: shared definitions for the obstacle-avoid waypoint steering core
// Sizes, sector bounds, angle constants, register indexes and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package oaws_pkg;

    // Scan geometry and waypoint count
    localparam int BEAMS            = 180;
    localparam int GOALS            = 2;
    localparam int LEFT_SECTOR_END  = 60;
    localparam int FRONT_SECTOR_END = 120;

    localparam logic [7:0] BEAM_LIMIT = 8'(BEAMS);
    localparam logic [7:0] LEFT_END   = 8'(LEFT_SECTOR_END);
    localparam logic [7:0] FRONT_END  = 8'(FRONT_SECTOR_END);
    localparam logic [7:0] BEAM_SAT   = 8'hFF;

    // Angles in 1/4096 rad
    localparam int PI_Q      = 12868;
    localparam int HALF_PI_Q = 6434;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 13;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int CW           = 28;   // rotation x/y width
    localparam int ZW           = 15;   // angle accumulator width
    localparam int AW           = 13;   // table entry width

    // Configuration register width and indexes
    localparam int CFG_DW = 16;

    typedef enum logic [2:0] {
        CFG_OBSTACLE_THRESHOLD = 3'd0,
        CFG_ARRIVE_THRESHOLD   = 3'd1,
        CFG_HEADING_TOLERANCE  = 3'd2,
        CFG_FIRST_GOAL_X       = 3'd3,
        CFG_FIRST_GOAL_Y       = 3'd4,
        CFG_SECOND_GOAL_X      = 3'd5,
        CFG_SECOND_GOAL_Y      = 3'd6
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_OBSTACLE_THRESHOLD = 16'd384;
    localparam logic [15:0] RST_ARRIVE_THRESHOLD   = 16'd128;
    localparam logic [13:0] RST_HEADING_TOLERANCE  = 14'd410;
    localparam logic [15:0] RST_FIRST_GOAL_X       = 16'd410;
    localparam logic [15:0] RST_FIRST_GOAL_Y       = 16'(-5120);
    localparam logic [15:0] RST_SECOND_GOAL_X      = 16'd410;
    localparam logic [15:0] RST_SECOND_GOAL_Y      = 16'(-512);

    // Turn rate codes, 0.5 rad/s units
    localparam logic signed [2:0] TURN_HARD_RIGHT = -3'sd2;
    localparam logic signed [2:0] TURN_RIGHT      = -3'sd1;
    localparam logic signed [2:0] TURN_NONE       = 3'sd0;
    localparam logic signed [2:0] TURN_LEFT       = 3'sd1;

    localparam logic SPEED_STOP    = 1'b0;
    localparam logic SPEED_FORWARD = 1'b1;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // atan(2^-i) in 1/4096 rad
    function automatic logic [AW-1:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic [AW-1:0] val;
        case (idx)
            4'd0:    val = 13'd3217;
            4'd1:    val = 13'd1899;
            4'd2:    val = 13'd1003;
            4'd3:    val = 13'd509;
            4'd4:    val = 13'd256;
            4'd5:    val = 13'd128;
            4'd6:    val = 13'd64;
            4'd7:    val = 13'd32;
            4'd8:    val = 13'd16;
            4'd9:    val = 13'd8;
            4'd10:   val = 13'd4;
            4'd11:   val = 13'd2;
            4'd12:   val = 13'd1;
            default: val = 13'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/obstacle_avoid_waypoint_steer_core.sv =====
// ----------------------------------------------------------------------------
// obstacle_avoid_waypoint_steer_core: laser obstacle avoidance and waypoint
// steering for a mobile robot, with an iterative CORDIC bearing unit.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall) carries one transaction per scan sample
//  (opcode 0: range_sample, scan_last) or per control tick (opcode 1: pos_x,
//  pos_y, heading). Output channel (out_valid / out_stall) carries the steering
//  command: linear_speed, angular_rate, avoiding, goal_index.
//  A scan sample that is not the last of its scan is absorbed and produces
//  nothing. The last sample of a scan goes through the emit step into the
//  output register. A tick that is held (avoiding), arrives at the waypoint or
//  lies on the x axis passes the check and emit steps; any other tick runs 13
//  CORDIC rotations on one shared add/subtract/shift unit, then the resolve,
//  decide and emit steps. in_stall stays high while a transaction is in work,
//  so a steering tick holds off new input until its command reaches the
//  output register, while a scan sample that is not the last leaves it ready.
//  The output register parts the two channels: a scan sample that makes no
//  result is taken while a command still waits. A new command waits in the
//  emit step until the receiver takes the old one (out_stall low).
//  Reset (rst_n low) loads the default thresholds and waypoints, clears the
//  command, scan state and waypoint select, and drops out_valid.
//  Configuration writes (cfg_wr_en) take effect at once; issue them while idle.
// ----------------------------------------------------------------------------
module obstacle_avoid_waypoint_steer_core
    import oaws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration write port
    input  logic                     cfg_wr_en,
    input  logic [2:0]               cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data,

    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic [15:0]              range_sample,
    input  logic                     scan_last,
    input  logic signed [15:0]       pos_x,
    input  logic signed [15:0]       pos_y,
    input  logic signed [14:0]       heading,

    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     linear_speed,
    output logic signed [2:0]        angular_rate,
    output logic                     avoiding,
    output logic                     goal_index
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ROTATE,
        S_RESOLVE,
        S_DECIDE,
        S_EMIT
    } state_t;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                    state_reg,        state_next;

    logic [15:0]               obst_thr_reg,     obst_thr_next;
    logic [15:0]               arrive_thr_reg,   arrive_thr_next;
    logic [13:0]               head_tol_reg,     head_tol_next;
    logic [15:0]               goal0_x_reg,      goal0_x_next;
    logic [15:0]               goal0_y_reg,      goal0_y_next;
    logic [15:0]               goal1_x_reg,      goal1_x_next;
    logic [15:0]               goal1_y_reg,      goal1_y_next;

    logic                      speed_cmd_reg,    speed_cmd_next;
    logic signed [2:0]         turn_cmd_reg,     turn_cmd_next;
    logic                      avoid_flag_reg,   avoid_flag_next;
    logic                      scan_hit_reg,     scan_hit_next;
    logic [7:0]                beam_count_reg,   beam_count_next;
    logic                      goal_sel_reg,     goal_sel_next;

    // tick working registers
    logic signed [16:0]        dx_reg,           dx_next;
    logic signed [16:0]        dy_reg,           dy_next;
    logic signed [14:0]        hd_reg,           hd_next;
    logic signed [CW-1:0]      cx_reg,           cx_next;
    logic signed [CW-1:0]      cy_reg,           cy_next;
    logic signed [ZW-1:0]      cz_reg,           cz_next;
    logic [ITER_W-1:0]         iter_reg,         iter_next;
    logic signed [14:0]        bearing_reg,      bearing_next;

    // output register
    logic                      out_valid_reg,    out_valid_next;
    logic                      out_speed_reg,    out_speed_next;
    logic signed [2:0]         out_turn_reg,     out_turn_next;
    logic                      out_avoid_reg,    out_avoid_next;
    logic                      out_goal_reg,     out_goal_next;

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    logic                      in_take;
    logic                      out_take;
    logic                      use_second;
    logic signed [15:0]        goal_x;
    logic signed [15:0]        goal_y;
    logic signed [16:0]        dx_abs17;
    logic signed [16:0]        dy_abs17;
    logic [15:0]               adx;
    logic [15:0]               ady;
    logic                      arrived;
    logic                      near;

    // shared rotation unit
    logic signed [CW-1:0]      x_shift;
    logic signed [CW-1:0]      y_shift;
    logic signed [ZW-1:0]      atan_step;
    logic                      rot_down;

    // bearing resolve
    logic [13:0]               ang_clamp;
    logic [13:0]               ang_quad;

    // heading error
    logic signed [15:0]        err;
    logic signed [15:0]        err_abs;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    assign use_second = (int'(goal_sel_reg) < GOALS) && goal_sel_reg;
    assign goal_x     = signed'(use_second ? goal1_x_reg : goal0_x_reg);
    assign goal_y     = signed'(use_second ? goal1_y_reg : goal0_y_reg);

    assign dx_abs17 = dx_reg[16] ? -dx_reg : dx_reg;
    assign dy_abs17 = dy_reg[16] ? -dy_reg : dy_reg;
    assign adx      = dx_abs17[15:0];
    assign ady      = dy_abs17[15:0];
    assign arrived  = (adx <= arrive_thr_reg) && (ady <= arrive_thr_reg);

    assign near = !scan_hit_reg && (beam_count_reg < BEAM_LIMIT)
                  && (range_sample < obst_thr_reg);

    assign x_shift   = cx_reg >>> iter_reg;
    assign y_shift   = cy_reg >>> iter_reg;
    assign atan_step = signed'({{(ZW-AW){1'b0}}, atan_lut(iter_reg)});
    assign rot_down  = (cy_reg > 0);

    assign err     = 16'(hd_reg) - 16'(bearing_reg);
    assign err_abs = err[15] ? -err : err;

    always_comb
    begin
        // clamp the first-quadrant angle to [0, pi/2]
        if (cz_reg < 0)
        begin
            ang_clamp = 14'd0;
        end
        else if (cz_reg > ZW'(HALF_PI_Q))
        begin
            ang_clamp = 14'(HALF_PI_Q);
        end
        else
        begin
            ang_clamp = cz_reg[13:0];
        end
        // mirror into the second quadrant when the goal lies behind
        ang_quad = dx_reg[16] ? (14'(PI_Q) - ang_clamp) : ang_clamp;
    end

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        obst_thr_next   = obst_thr_reg;
        arrive_thr_next = arrive_thr_reg;
        head_tol_next   = head_tol_reg;
        goal0_x_next    = goal0_x_reg;
        goal0_y_next    = goal0_y_reg;
        goal1_x_next    = goal1_x_reg;
        goal1_y_next    = goal1_y_reg;
        speed_cmd_next  = speed_cmd_reg;
        turn_cmd_next   = turn_cmd_reg;
        avoid_flag_next = avoid_flag_reg;
        scan_hit_next   = scan_hit_reg;
        beam_count_next = beam_count_reg;
        goal_sel_next   = goal_sel_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        hd_next         = hd_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        iter_next       = iter_reg;
        bearing_next    = bearing_reg;
        out_valid_next  = out_take ? 1'b0 : out_valid_reg;
        out_speed_next  = out_speed_reg;
        out_turn_next   = out_turn_reg;
        out_avoid_next  = out_avoid_reg;
        out_goal_next   = out_goal_reg;

        // configuration writes
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_OBSTACLE_THRESHOLD: obst_thr_next   = cfg_data;
                CFG_ARRIVE_THRESHOLD:   arrive_thr_next = cfg_data;
                CFG_HEADING_TOLERANCE:  head_tol_next   = cfg_data[13:0];
                CFG_FIRST_GOAL_X:       goal0_x_next    = cfg_data;
                CFG_FIRST_GOAL_Y:       goal0_y_next    = cfg_data;
                CFG_SECOND_GOAL_X:      goal1_x_next    = cfg_data;
                CFG_SECOND_GOAL_Y:      goal1_y_next    = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (opcode == OP_SCAN)
                    begin
                        // first near beam picks the avoidance command by sector
                        if (near)
                        begin
                            scan_hit_next = 1'b1;
                            if (beam_count_reg < LEFT_END)
                            begin
                                speed_cmd_next = SPEED_FORWARD;
                                turn_cmd_next  = TURN_LEFT;
                            end
                            else if (beam_count_reg < FRONT_END)
                            begin
                                speed_cmd_next = SPEED_STOP;
                                turn_cmd_next  = TURN_HARD_RIGHT;
                            end
                            else
                            begin
                                speed_cmd_next = SPEED_FORWARD;
                                turn_cmd_next  = TURN_RIGHT;
                            end
                        end
                        if (beam_count_reg != BEAM_SAT)
                        begin
                            beam_count_next = beam_count_reg + 8'd1;
                        end
                        if (scan_last)
                        begin
                            avoid_flag_next = scan_hit_reg || near;
                            scan_hit_next   = 1'b0;
                            beam_count_next = 8'd0;
                            state_next      = S_EMIT;
                        end
                    end
                    else
                    begin
                        dx_next    = 17'(goal_x) - 17'(pos_x);
                        dy_next    = 17'(goal_y) - 17'(pos_y);
                        hd_next    = heading;
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                if (avoid_flag_reg)
                begin
                    // hold the avoidance command
                    state_next = S_EMIT;
                end
                else if (arrived)
                begin
                    speed_cmd_next = SPEED_STOP;
                    turn_cmd_next  = TURN_NONE;
                    if (int'(goal_sel_reg) + 1 >= GOALS)
                    begin
                        goal_sel_next = 1'b0;
                    end
                    else
                    begin
                        goal_sel_next = goal_sel_reg + 1'b1;
                    end
                    state_next = S_EMIT;
                end
                else if (dy_reg == 17'sd0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cx_next    = signed'({{(CW-24){1'b0}}, adx, 8'd0});
                    cy_next    = signed'({{(CW-24){1'b0}}, ady, 8'd0});
                    cz_next    = '0;
                    iter_next  = '0;
                    state_next = S_ROTATE;
                end
            end

            S_ROTATE:
            begin
                if (rot_down)
                begin
                    cx_next = cx_reg + y_shift;
                    cy_next = cy_reg - x_shift;
                    cz_next = cz_reg + atan_step;
                end
                else
                begin
                    cx_next = cx_reg - y_shift;
                    cy_next = cy_reg + x_shift;
                    cz_next = cz_reg - atan_step;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_RESOLVE;
                end
            end

            S_RESOLVE:
            begin
                if (dy_reg > 0)
                begin
                    bearing_next = signed'({1'b0, ang_quad});
                end
                else
                begin
                    bearing_next = -signed'({1'b0, ang_quad});
                end
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                if (err_abs > signed'({2'b00, head_tol_reg}))
                begin
                    speed_cmd_next = SPEED_STOP;
                    turn_cmd_next  = (hd_reg <= bearing_reg) ? TURN_LEFT : TURN_RIGHT;
                end
                else
                begin
                    speed_cmd_next = SPEED_FORWARD;
                    turn_cmd_next  = TURN_NONE;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_speed_next = speed_cmd_reg;
                    out_turn_next  = turn_cmd_reg;
                    out_avoid_next = avoid_flag_reg;
                    out_goal_next  = goal_sel_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            obst_thr_reg   <= RST_OBSTACLE_THRESHOLD;
            arrive_thr_reg <= RST_ARRIVE_THRESHOLD;
            head_tol_reg   <= RST_HEADING_TOLERANCE;
            goal0_x_reg    <= RST_FIRST_GOAL_X;
            goal0_y_reg    <= RST_FIRST_GOAL_Y;
            goal1_x_reg    <= RST_SECOND_GOAL_X;
            goal1_y_reg    <= RST_SECOND_GOAL_Y;
            speed_cmd_reg  <= SPEED_STOP;
            turn_cmd_reg   <= TURN_NONE;
            avoid_flag_reg <= 1'b0;
            scan_hit_reg   <= 1'b0;
            beam_count_reg <= 8'd0;
            goal_sel_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            obst_thr_reg   <= obst_thr_next;
            arrive_thr_reg <= arrive_thr_next;
            head_tol_reg   <= head_tol_next;
            goal0_x_reg    <= goal0_x_next;
            goal0_y_reg    <= goal0_y_next;
            goal1_x_reg    <= goal1_x_next;
            goal1_y_reg    <= goal1_y_next;
            speed_cmd_reg  <= speed_cmd_next;
            turn_cmd_reg   <= turn_cmd_next;
            avoid_flag_reg <= avoid_flag_next;
            scan_hit_reg   <= scan_hit_next;
            beam_count_reg <= beam_count_next;
            goal_sel_reg   <= goal_sel_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        hd_reg        <= hd_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        iter_reg      <= iter_next;
        bearing_reg   <= bearing_next;
        out_speed_reg <= out_speed_next;
        out_turn_reg  <= out_turn_next;
        out_avoid_reg <= out_avoid_next;
        out_goal_reg  <= out_goal_next;
    end

    assign out_valid    = out_valid_reg;
    assign linear_speed = out_speed_reg;
    assign angular_rate = out_turn_reg;
    assign avoiding     = out_avoid_reg;
    assign goal_index   = out_goal_reg;

endmodule

// ===== verif/obstacle_avoid_waypoint_steer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obstacle_avoid_waypoint_steer_core_tb: self-checking bench for the steering core
// Sends laser scan samples and pose ticks through the valid/stall input channel
// and checks each steering command against a cycle-free predictor of the core or a
// typed row's command. It opens with a short table of directed transactions, then
// runs random scans and ticks under five register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module obstacle_avoid_waypoint_steer_core_tb;
    import oaws_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 24;    // longest tick runs all CORDIC rotations
    localparam int PHASE_ITEMS   = 180;

    // One input transaction, fields at the port widths
    typedef struct packed {
        logic               op;
        logic [15:0]        rng;
        logic               last;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [14:0] hd;
    } steer_item_t;

    // One steering command
    typedef struct packed {
        logic              speed;
        logic signed [2:0] turn;
        logic              avoid;
        logic              goal;
    } steer_cmd_t;

    // One row of the directed table; typed rows carry their command
    typedef struct packed {
        steer_item_t item;
        logic        typed;
        steer_cmd_t  cmd;
    } steer_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [2:0]          cfg_index;
    logic [CFG_DW-1:0]   cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                opcode;
    logic [15:0]         range_sample;
    logic                scan_last;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;
    logic signed [14:0]  heading;
    logic                out_valid;
    logic                out_stall;
    logic                linear_speed;
    logic signed [2:0]   angular_rate;
    logic                avoiding;
    logic                goal_index;

    obstacle_avoid_waypoint_steer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .range_sample (range_sample),
        .scan_last    (scan_last),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .heading      (heading),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .linear_speed (linear_speed),
        .angular_rate (angular_rate),
        .avoiding     (avoiding),
        .goal_index   (goal_index)
    );

    // ------------------------------------------------------------------------
    // Predictor state: registers and the core's architectural state
    // ------------------------------------------------------------------------
    int                obst_limit;
    int                arrive_limit;
    int                turn_tolerance;
    int                goal_x [2];
    int                goal_y [2];

    logic              speed_now;
    logic signed [2:0] turn_now;
    logic              avoid_now;
    logic              hit_pending;
    logic [7:0]        beam_idx;
    int                goal_idx;

    // Commands predicted for accepted transactions, oldest first
    steer_cmd_t        pending_cmds [$];
    steer_row_t        dir_rows [$];

    int                n_items;
    int                n_results;
    int                n_scans;
    int                n_arrivals;
    int                fail_count;
    int                cycle_count;
    bit                burst_mode;

    // ------------------------------------------------------------------------
    // Bearing computation
    // ------------------------------------------------------------------------
    function automatic int atan_step(input int i);
        case (i)
            0:       return 3217;
            1:       return 1899;
            2:       return 1003;
            3:       return 509;
            4:       return 256;
            5:       return 128;
            6:       return 64;
            7:       return 32;
            8:       return 16;
            9:       return 8;
            10:      return 4;
            11:      return 2;
            12:      return 1;
            default: return 0;
        endcase
    endfunction

    // First-quadrant arctangent of ay/ax by vectoring CORDIC, clamped to 0..pi/2
    function automatic int quadrant_angle(input longint ax, input longint ay);
        longint x;
        longint y;
        longint xs;
        longint ys;
        int     z;
        x = ax * 256;
        y = ay * 256;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z += atan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= atan_step(i);
            end
        end
        if (z < 0)
            z = 0;
        if (z > HALF_PI_Q)
            z = HALF_PI_Q;
        return z;
    endfunction

    // Full-circle bearing of the vector (dx, dy), unwrapped into -pi..pi
    function automatic int goal_bearing(input int dx, input int dy);
        int a;
        a = quadrant_angle(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
        if (dx < 0)
            a = PI_Q - a;
        return (dy > 0) ? a : -a;
    endfunction

    function automatic void current_goal(output int gx, output int gy);
        int sel;
        sel = (goal_idx < GOALS && goal_idx == 1) ? 1 : 0;
        gx = goal_x[sel];
        gy = goal_y[sel];
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: advance the state by one accepted transaction and report
    // the command it emits, if any
    // ------------------------------------------------------------------------
    function automatic bit steer_predict(input steer_item_t it, output steer_cmd_t cmd);
        int gx;
        int gy;
        int dx;
        int dy;
        int bearing;
        int err;
        int hd;
        hd  = int'(it.hd);
        cmd = '0;
        if (it.op == OP_SCAN)
        begin
            // only the first near beam inside the scan width steers
            if (!hit_pending && beam_idx < BEAM_LIMIT && int'(it.rng) < obst_limit)
            begin
                hit_pending = 1'b1;
                if (beam_idx < LEFT_END)
                begin
                    speed_now = SPEED_FORWARD;
                    turn_now  = TURN_LEFT;
                end
                else if (beam_idx < FRONT_END)
                begin
                    speed_now = SPEED_STOP;
                    turn_now  = TURN_HARD_RIGHT;
                end
                else
                begin
                    speed_now = SPEED_FORWARD;
                    turn_now  = TURN_RIGHT;
                end
            end
            if (beam_idx != BEAM_SAT)
                beam_idx++;
            if (!it.last)
                return 1'b0;
            avoid_now   = hit_pending;
            hit_pending = 1'b0;
            beam_idx    = '0;
            n_scans++;
        end
        else if (!avoid_now)
        begin
            current_goal(gx, gy);
            dx = gx - int'(it.px);
            dy = gy - int'(it.py);
            if ((dx < 0 ? -dx : dx) <= arrive_limit && (dy < 0 ? -dy : dy) <= arrive_limit)
            begin
                // arrival: stop and move on to the next waypoint
                speed_now = SPEED_STOP;
                turn_now  = TURN_NONE;
                goal_idx  = (goal_idx + 1 >= GOALS) ? 0 : goal_idx + 1;
                n_arrivals++;
            end
            else if (dy != 0)
            begin
                bearing = goal_bearing(dx, dy);
                err     = hd - bearing;
                if ((err < 0 ? -err : err) > turn_tolerance)
                begin
                    speed_now = SPEED_STOP;
                    turn_now  = (hd <= bearing) ? TURN_LEFT : TURN_RIGHT;
                end
                else
                begin
                    speed_now = SPEED_FORWARD;
                    turn_now  = TURN_NONE;
                end
            end
        end
        cmd.speed = speed_now;
        cmd.turn  = turn_now;
        cmd.avoid = avoid_now;
        cmd.goal  = 1'(goal_idx);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic steer_cmd_t mk_cmd(input logic s, input logic signed [2:0] t,
                                          input logic a, input logic g);
        steer_cmd_t c;
        c.speed = s;
        c.turn  = t;
        c.avoid = a;
        c.goal  = g;
        return c;
    endfunction

    function automatic void add_row(input logic op, input logic [15:0] rng, input logic last,
                                    input int px, input int py, input int hd,
                                    input logic typed, input steer_cmd_t cmd);
        steer_row_t r;
        r.item.op   = op;
        r.item.rng  = rng;
        r.item.last = last;
        r.item.px   = 16'(px);
        r.item.py   = 16'(py);
        r.item.hd   = 15'(hd);
        r.typed     = typed;
        r.cmd       = cmd;
        dir_rows.push_back(r);
    endfunction

    function automatic int sat16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int random_heading();
        return int'($urandom_range(0, 2 * PI_Q)) - PI_Q;
    endfunction

    function automatic int random_pos();
        return int'($signed(16'($urandom)));
    endfunction

    // Gap before a transaction: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] beam_range(input bit near);
        if (near)
            return (obst_limit == 0) ? 16'd0 : 16'($urandom_range(0, obst_limit - 1));
        return 16'($urandom_range(obst_limit, 65535));
    endfunction

    // Random tick, biased toward arrival, the x axis and headings near the bearing
    function automatic steer_item_t make_tick();
        steer_item_t it;
        int          gx;
        int          gy;
        int          px;
        int          py;
        int          hd;
        int          reach;
        int          tol;
        int          r;
        current_goal(gx, gy);
        px    = random_pos();
        py    = random_pos();
        hd    = random_heading();
        reach = arrive_limit + 2;
        r     = $urandom_range(0, 99);
        if (r < 30)
        begin
            px = sat16(gx + int'($urandom_range(0, 2 * reach)) - reach);
            py = sat16(gy + int'($urandom_range(0, 2 * reach)) - reach);
        end
        else if (r < 40)
            py = gy;
        else if (r < 65 && py != gy)
        begin
            tol = turn_tolerance + 3;
            hd  = goal_bearing(gx - px, gy - py) + int'($urandom_range(0, 2 * tol)) - tol;
            if (hd > PI_Q)
                hd = PI_Q;
            if (hd < -PI_Q)
                hd = -PI_Q;
        end
        it.op   = OP_TICK;
        it.rng  = 16'($urandom);
        it.last = 1'($urandom);
        it.px   = 16'(px);
        it.py   = 16'(py);
        it.hd   = 15'(hd);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input channel driver: hold the payload until the core takes it, then
    // predict its command at the accepting edge
    // ------------------------------------------------------------------------
    task automatic drive_item(input steer_item_t it, input logic typed,
                              input steer_cmd_t typed_cmd);
        int         gap;
        steer_cmd_t cmd;
        gap = burst_mode ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= it.op;
        range_sample <= it.rng;
        scan_last    <= it.last;
        pos_x        <= it.px;
        pos_y        <= it.py;
        heading      <= it.hd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (steer_predict(it, cmd))
            pending_cmds.push_back(typed ? typed_cmd : cmd);
        n_items++;
    endtask

    // Drop valid and hold off until every predicted command has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    // Let a trailing scan sample finish before the registers change
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leave the write enable high; the caller drops it after the last register
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_OBSTACLE_THRESHOLD: obst_limit     = int'(val);
            CFG_ARRIVE_THRESHOLD:   arrive_limit   = int'(val);
            CFG_HEADING_TOLERANCE:  turn_tolerance = int'(val[13:0]);
            CFG_FIRST_GOAL_X:       goal_x[0]      = int'($signed(val));
            CFG_FIRST_GOAL_Y:       goal_y[0]      = int'($signed(val));
            CFG_SECOND_GOAL_X:      goal_x[1]      = int'($signed(val));
            CFG_SECOND_GOAL_Y:      goal_y[1]      = int'($signed(val));
            default:                ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] obst, input logic [15:0] arrive,
                                 input logic [15:0] tol,
                                 input logic [15:0] g0x, input logic [15:0] g0y,
                                 input logic [15:0] g1x, input logic [15:0] g1y);
        write_reg(CFG_OBSTACLE_THRESHOLD, obst);
        write_reg(CFG_ARRIVE_THRESHOLD, arrive);
        write_reg(CFG_HEADING_TOLERANCE, tol);
        write_reg(CFG_FIRST_GOAL_X, g0x);
        write_reg(CFG_FIRST_GOAL_Y, g0y);
        write_reg(CFG_SECOND_GOAL_X, g1x);
        write_reg(CFG_SECOND_GOAL_Y, g1y);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly whole scans with planted near beams and bursts
    // of ticks, with stray ticks dropped into scans now and then
    // ------------------------------------------------------------------------
    task automatic run_traffic(input int quota);
        steer_item_t it;
        int          start_items;
        int          len;
        int          hit_at;
        int          extra_hit;
        int          r;
        start_items = n_items;
        while (n_items - start_items < quota)
        begin
            burst_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 19) == 0)
                wait_drained();
            if ($urandom_range(0, 99) < 30)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    len = $urandom_range(1, LEFT_SECTOR_END);
                else if (r < 80)
                    len = $urandom_range(LEFT_SECTOR_END + 1, BEAMS - 1);
                else if (r < 95)
                    len = BEAMS;
                else
                    len = $urandom_range(250, 300);    // run the beam counter into saturation
                hit_at    = ($urandom_range(0, 9) < 6) ? int'($urandom_range(0, len - 1)) : -1;
                extra_hit = ($urandom_range(0, 9) < 3) ? int'($urandom_range(0, len - 1)) : -1;
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 32) == 0)
                        drive_item(make_tick(), 1'b0, '0);
                    it.op   = OP_SCAN;
                    it.last = (k == len - 1);
                    if (k == hit_at || k == extra_hit)
                        it.rng = beam_range(1'b1);
                    else if ($urandom_range(0, 11) == 0)
                        it.rng = 16'($urandom);
                    else
                        it.rng = beam_range(1'b0);
                    it.px = 16'($urandom);
                    it.py = 16'($urandom);
                    it.hd = 15'(random_heading());
                    drive_item(it, 1'b0, '0);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    drive_item(make_tick(), 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: alternate ready stretches with stalls, mostly short, a few
    // long; long ready stretches give runs with no stalling at all
    // ------------------------------------------------------------------------
    initial
    begin : receiver_stall
        int run;
        int hold;
        int r;
        forever
        begin
            run  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
            r    = $urandom_range(0, 99);
            hold = (r < 70) ? $urandom_range(1, 3) :
                   (r < 95) ? $urandom_range(4, 10) : $urandom_range(20, 60);
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
            out_stall <= 1'b1;
            repeat (hold) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted command with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_commands
        steer_cmd_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_cmds.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: command with no transaction behind it: speed %0d turn %0d",
                             $realtime, linear_speed, angular_rate);
                fail_count++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (want.speed !== linear_speed || want.turn !== angular_rate ||
                    want.avoid !== avoiding || want.goal !== goal_index)
                begin
                    if (fail_count < 10)
                        $display("%0t: command mismatch: expected speed %0d turn %0d avoid %0d goal %0d, got speed %0d turn %0d avoid %0d goal %0d",
                                 $realtime, want.speed, want.turn, want.avoid, want.goal,
                                 linear_speed, angular_rate, avoiding, goal_index);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("stuck after %0d cycles with %0d commands outstanding",
                 cycle_count, pending_cmds.size());
        $display("** obstacle_avoid_waypoint_steer_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        n_items    = 0;
        n_results  = 0;
        n_scans    = 0;
        n_arrivals = 0;
        fail_count = 0;
        burst_mode = 1'b0;

        // predictor at its reset state
        obst_limit     = int'(RST_OBSTACLE_THRESHOLD);
        arrive_limit   = int'(RST_ARRIVE_THRESHOLD);
        turn_tolerance = int'(RST_HEADING_TOLERANCE);
        goal_x[0]      = int'($signed(RST_FIRST_GOAL_X));
        goal_y[0]      = int'($signed(RST_FIRST_GOAL_Y));
        goal_x[1]      = int'($signed(RST_SECOND_GOAL_X));
        goal_y[1]      = int'($signed(RST_SECOND_GOAL_Y));
        speed_now      = SPEED_STOP;
        turn_now       = TURN_NONE;
        avoid_now      = 1'b0;
        hit_pending    = 1'b0;
        beam_idx       = '0;
        goal_idx       = 0;

        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_OBSTACLE_THRESHOLD;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        opcode       <= OP_SCAN;
        range_sample <= '0;
        scan_last    <= 1'b0;
        pos_x        <= '0;
        pos_y        <= '0;
        heading      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, reset registers: waypoint 0 at (410, -5120),
        // waypoint 1 at (410, -512), arrival window 128, near below 384.
        // Steer toward waypoint 0 from the origin
        add_row(OP_TICK, 16'h0000, 1'b0, 0, 0, 0, 1'b0, '0);
        // Exactly on waypoint 0; range and scan_last are ignored on a tick
        add_row(OP_TICK, 16'hFFFF, 1'b1, 410, -5120, 0, 1'b1,
                mk_cmd(SPEED_STOP, TURN_NONE, 1'b0, 1'b1));
        // Arrival window edge on both axes at waypoint 1, wraps to waypoint 0
        add_row(OP_TICK, 16'h5A5A, 1'b0, 538, -640, 0, 1'b1,
                mk_cmd(SPEED_STOP, TURN_NONE, 1'b0, 1'b0));
        // Just outside the window on the x axis: hold the command
        add_row(OP_TICK, 16'h0000, 1'b1, 539, -5120, 0, 1'b1,
                mk_cmd(SPEED_STOP, TURN_NONE, 1'b0, 1'b0));
        // Pose and heading extremes
        add_row(OP_TICK, 16'h0000, 1'b0, 32767, -32768, PI_Q, 1'b0, '0);
        add_row(OP_TICK, 16'h0000, 1'b0, -32768, 32767, -PI_Q, 1'b0, '0);
        // Straight above the goal: facing it drives forward, heading 0 turns right
        add_row(OP_TICK, 16'h0000, 1'b0, 410, 0, -HALF_PI_Q, 1'b0, '0);
        add_row(OP_TICK, 16'h0000, 1'b0, 410, -4991, 0, 1'b0, '0);
        // One-sample scan, beam 0 at range zero: avoid with a left turn
        add_row(OP_SCAN, 16'h0000, 1'b1, -1, 1, PI_Q, 1'b1,
                mk_cmd(SPEED_FORWARD, TURN_LEFT, 1'b1, 1'b0));
        // Tick while avoiding, on the waypoint: held, no arrival
        add_row(OP_TICK, 16'h0000, 1'b0, 410, -5120, 0, 1'b1,
                mk_cmd(SPEED_FORWARD, TURN_LEFT, 1'b1, 1'b0));
        // Scan: far, tick in between, just below the threshold, a second near
        // beam that is ignored, last beam at the threshold
        add_row(OP_SCAN, 16'hFFFF, 1'b0, 32767, -32768, 0, 1'b0, '0);
        add_row(OP_TICK, 16'h0000, 1'b1, 0, 0, 0, 1'b1,
                mk_cmd(SPEED_FORWARD, TURN_LEFT, 1'b1, 1'b0));
        add_row(OP_SCAN, 16'd383, 1'b0, 0, 0, 0, 1'b0, '0);
        add_row(OP_SCAN, 16'h0000, 1'b0, 0, 0, 0, 1'b0, '0);
        add_row(OP_SCAN, 16'd384, 1'b1, 0, 0, 0, 1'b0, '0);
        // Clear scan drops avoidance
        add_row(OP_SCAN, 16'hFFFF, 1'b1, 0, 0, 0, 1'b0, '0);
        add_row(OP_TICK, 16'h0000, 1'b0, 410, -5120, 0, 1'b1,
                mk_cmd(SPEED_STOP, TURN_NONE, 1'b0, 1'b1));
        add_row(OP_TICK, 16'hFFFF, 1'b1, 410, -511, PI_Q, 1'b0, '0);
        foreach (dir_rows[k])
            drive_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].cmd);

        // Random phases, each under its own register set
        run_traffic(PHASE_ITEMS);

        // Zero thresholds, waypoints at opposite corners
        settle();
        load_settings(16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        run_traffic(PHASE_ITEMS);

        // Full-scale thresholds, waypoints around the origin
        settle();
        load_settings(16'hFFFF, 16'hFFFF, 16'(PI_Q), 16'd0, 16'd0, 16'hFFFF, 16'd1);
        run_traffic(PHASE_ITEMS);

        // Random register sets
        settle();
        load_settings(16'($urandom_range(200, 3000)), 16'($urandom_range(0, 600)),
                      16'($urandom_range(0, PI_Q)), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
        run_traffic(PHASE_ITEMS);

        settle();
        load_settings(16'($urandom_range(100, 5000)), 16'($urandom_range(50, 400)),
                      16'($urandom_range(100, 2000)),
                      16'(int'($urandom_range(0, 16000)) - 8000),
                      16'(int'($urandom_range(0, 16000)) - 8000),
                      16'(int'($urandom_range(0, 16000)) - 8000),
                      16'(int'($urandom_range(0, 16000)) - 8000));
        run_traffic(PHASE_ITEMS);

        // Drain and let the core go quiet
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_cmds.size() != 0)
        begin
            $display("%0d commands never came out", pending_cmds.size());
            fail_count += pending_cmds.size();
        end

        $display("ran %0d transactions in %0d cycles: %0d scans closed, %0d waypoint arrivals",
                 n_items, cycle_count, n_scans, n_arrivals);
        $display("checked %0d commands over five register sets, %0d mismatches",
                 n_results, fail_count);
        if (fail_count == 0)
            $display("** obstacle_avoid_waypoint_steer_core: PASSED **");
        else
            $display("** obstacle_avoid_waypoint_steer_core: FAILED **");
        $finish;
    end

endmodule
